### design/mps_pkg.sv
// Package for the map path sanitizer: beat types, path state and character codes.
// No dependencies; used by mps_step and map_path_sanitizer.
package mps_pkg;

  // Character codes
  localparam logic [7:0] CTRL_LIMIT = 8'd32;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  // lookup_kind codes
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_INDIRECT = 2'd1;
  localparam logic [1:0] KIND_DIRECT   = 2'd2;

  // Verdict codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SLASH   = 2'd1;
  localparam logic [1:0] ST_CONTROL = 2'd2;
  localparam logic [1:0] ST_QUOTE   = 2'd3;

  // Results one input beat can cause
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       final_res;
    logic [1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic       escape_on;
    logic       dquote_on;
    logic       prev_was_slash;
    logic       held_valid;
    logic [7:0] held_byte;
    logic [1:0] out_count;
    logic [1:0] in_count;
    logic       first_is_slash;
    logic       any_slash;
    logic       bad_control;
  } path_state_t;

endpackage

### design/map_path_sanitizer.sv
// Top level of the map path sanitizer: path state, config register, result queue.
// Depends on mps_pkg and mps_step.
//
// Usage:
//   in channel  (in_valid / in_stall / in_data): one raw path byte per beat,
//     last_byte marks the end of a path.
//   out channel (out_valid / out_stall / out_data): cleaned bytes, then one
//     verdict beat (final_res set, status valid) per path.
//   cfg channel (cfg_valid / cfg_ready / cfg_data; cfg_ready is always high):
//     lookup_kind, written only while no path is in flight (left to the user).
// Result beats are registered in the result queue before they are offered.
//   Throughput: one input beat per cycle while each beat causes at most one
//   result and out_stall is low; an input beat causes up to three results and
//   the output drains one per cycle, while out_stall is low, through a
//   four-entry result queue. in_stall rises when the queue holds two or more
//   beats.
// Reset clears the path state, the queue and lookup_kind. A stalled receiver
//   simply fills the queue, then in_stall holds off the sender.
module map_path_sanitizer
  import mps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  path_state_t              path_st;
  path_state_t              path_st_next;
  logic [1:0]               lookup_kind;
  out_beat_t [MAX_RES-1:0]  step_res;
  logic [1:0]               step_count;

  out_beat_t                queue [4];
  logic [1:0]               head;
  logic [1:0]               tail;
  logic [2:0]               count;
  logic                     in_take;
  logic                     out_take;
  logic [1:0]               push_n;

  mps_step u_step (
    .cur         (path_st),
    .beat        (in_data),
    .lookup_kind (lookup_kind),
    .nxt         (path_st_next),
    .res         (step_res),
    .res_count   (step_count)
  );

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = (count > 3'd1);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign out_take  = out_valid && !out_stall;
  assign push_n    = in_take ? step_count : 2'd0;
  assign out_data  = queue[head];

  // config register and path state
  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_kind <= KIND_NONE;
      path_st     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) lookup_kind <= cfg_data;
      if (in_take) path_st <= path_st_next;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 3'd0;
    end else begin
      tail  <= tail + push_n;
      if (out_take) head <= head + 2'd1;
      count <= count + {1'b0, push_n} - {2'b0, out_take};
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_n) queue[tail + 2'(i)] <= step_res[i];
    end
  end

endmodule

### design/mps_step.sv
// Per-byte cleaning logic of the map path sanitizer: next path state and result beats.
// Depends on mps_pkg.
module mps_step
  import mps_pkg::*;
(
  input  path_state_t           cur,
  input  in_beat_t              beat,
  input  logic [1:0]            lookup_kind,
  output path_state_t           nxt,
  output out_beat_t [MAX_RES-1:0] res,
  output logic [1:0]            res_count
);

  always_comb begin
    path_state_t st;
    logic        keep;
    logic        drop;
    logic [1:0]  verdict;
    logic [1:0]  n;
    logic [7:0]  b;

    st      = cur;
    keep    = 1'b1;
    drop    = 1'b0;
    verdict = ST_OK;
    n       = 2'd0;
    b       = beat.byte_in;
    res     = '0;

    // slash scan over raw bytes
    if (cur.in_count == 2'd0 && b == CH_SLASH) st.first_is_slash = 1'b1;
    if (b == CH_SLASH) st.any_slash = 1'b1;
    if (cur.in_count < 2'd2) st.in_count = cur.in_count + 2'd1;

    // quote, escape, control and slash-run handling
    if (!cur.escape_on) begin
      if (b == CH_DQUOTE) begin
        st.dquote_on = ~cur.dquote_on;
        keep = 1'b0;
      end else begin
        if (!cur.dquote_on) begin
          if (b < CTRL_LIMIT) begin
            st.bad_control = 1'b1;
            keep = 1'b0;
          end else if (b == CH_BSLASH) begin
            st.escape_on = 1'b1;
            keep = 1'b0;
          end
        end
        if (keep) begin
          if (b == CH_SLASH) begin
            if (cur.prev_was_slash) keep = 1'b0;
            else st.prev_was_slash = 1'b1;
          end else begin
            st.prev_was_slash = 1'b0;
          end
        end
      end
      if (keep) st.escape_on = 1'b0;
    end else begin
      st.escape_on = 1'b0;
    end

    // emit the held byte, hold the new one
    if (keep) begin
      if (cur.held_valid) begin
        res[n] = '{char_out: cur.held_byte, char_valid: 1'b1, final_res: 1'b0, status: ST_OK};
        n = n + 2'd1;
      end
      st.held_byte  = b;
      st.held_valid = 1'b1;
      if (st.out_count < 2'd2) st.out_count = st.out_count + 2'd1;
    end

    // end of path: trailing slash, verdict, clear
    if (beat.last_byte) begin
      drop = (st.out_count >= 2'd2) && (st.in_count >= 2'd2) && (st.held_byte == CH_SLASH);
      if (st.held_valid && !drop) begin
        res[n] = '{char_out: st.held_byte, char_valid: 1'b1, final_res: 1'b0, status: ST_OK};
        n = n + 2'd1;
      end
      if (lookup_kind != KIND_NONE) begin
        if (st.any_slash) begin
          if (lookup_kind == KIND_INDIRECT || !st.first_is_slash) verdict = ST_SLASH;
        end else if (lookup_kind == KIND_DIRECT) begin
          verdict = ST_SLASH;
        end
      end
      if (verdict == ST_OK && st.bad_control) verdict = ST_CONTROL;
      if (verdict == ST_OK && st.dquote_on) verdict = ST_QUOTE;
      res[n] = '{char_out: 8'd0, char_valid: 1'b0, final_res: 1'b1, status: verdict};
      n = n + 2'd1;
      st = '0;
    end

    nxt       = st;
    res_count = n;
  end

endmodule
